/* hw/rtl/slcd_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package slcd_pkg;

    localparam int NUM_CHANNELS = 32;
    localparam int MASK_W       = 32;
    localparam int LANES        = 4;
    localparam int BOARD_W      = 3;
    localparam int MAX_BOARDS   = 8;
    localparam int NUM_BOARDS   = (NUM_CHANNELS / LANES > MAX_BOARDS) ?
                                  MAX_BOARDS : NUM_CHANNELS / LANES;
    localparam int CH_W         = 5;
    localparam int KIND_W       = 3;
    localparam int TICK_W       = 8;
    localparam int LAMP_W       = 2;
    localparam int CFG_IDX_W    = 2;

    localparam logic [BOARD_W-1:0] LAST_BOARD  = BOARD_W'(NUM_BOARDS - 1);
    localparam logic [TICK_W-1:0]  FLASH_SPLIT = 8'd50;
    localparam logic [TICK_W-1:0]  RUN_TICKS   = 8'd3;

    localparam logic [KIND_W-1:0] KIND_LOAD      = 3'd0;
    localparam logic [KIND_W-1:0] KIND_AUTOFLASH = 3'd1;
    localparam logic [KIND_W-1:0] KIND_ALL_RED   = 3'd2;
    localparam logic [KIND_W-1:0] KIND_OFF       = 3'd3;
    localparam logic [KIND_W-1:0] KIND_TICK      = 3'd4;

    localparam logic [LAMP_W-1:0] LAMP_DARK   = 2'd0;
    localparam logic [LAMP_W-1:0] LAMP_GREEN  = 2'd1;
    localparam logic [LAMP_W-1:0] LAMP_YELLOW = 2'd2;
    localparam logic [LAMP_W-1:0] LAMP_RED    = 2'd3;

    localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_ENABLED = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FLASH_YELLOW    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FLASH_RED       = 2'd2;

    localparam logic [MASK_W-1:0] ENABLED_RESET      = 32'hFFFF_FFFF;
    localparam logic [MASK_W-1:0] FLASH_YELLOW_RESET = 32'h7777_7777;
    localparam logic [MASK_W-1:0] FLASH_RED_RESET    = 32'h8888_8888;

    typedef struct packed {
        logic [MASK_W-1:0] green;
        logic [MASK_W-1:0] yellow;
        logic [MASK_W-1:0] red;
        logic [MASK_W-1:0] flash;
    } masks_t;

    typedef struct packed {
        logic green;
        logic yellow;
        logic red;
        logic flash;
    } lamp_bits_t;

    typedef logic [LANES-1:0][LAMP_W-1:0] codes_t;

endpackage

`default_nettype wire

/* hw/rtl/slcd_lane.sv */
`timescale 1ns / 1ps
`default_nettype none

module slcd_lane (
    input  slcd_pkg::lamp_bits_t        bits,
    input  logic                        late,
    output logic [slcd_pkg::LAMP_W-1:0] code
);
    import slcd_pkg::*;

    always_comb
    begin
        priority if (bits.flash)
        begin
            priority if (bits.green)
                code = late ? LAMP_GREEN : LAMP_DARK;
            else if (bits.yellow && bits.red)
                code = late ? LAMP_RED : LAMP_YELLOW;
            else if (bits.red)
                code = late ? LAMP_RED : LAMP_DARK;
            else
                // yellow, or no color at all
                code = late ? LAMP_YELLOW : LAMP_DARK;
        end
        else if (bits.green)
            code = LAMP_GREEN;
        else if (bits.yellow)
            code = LAMP_YELLOW;
        else if (bits.red)
            code = LAMP_RED;
        else
            code = LAMP_DARK;
    end

endmodule

`default_nettype wire

/* hw/rtl/slcd_state.sv */
`timescale 1ns / 1ps
`default_nettype none

module slcd_state (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_write,
    input  logic [slcd_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [slcd_pkg::MASK_W-1:0]    cfg_data,
    input  logic                           take,
    input  logic [slcd_pkg::KIND_W-1:0]    kind,
    input  slcd_pkg::masks_t               load_masks,
    output slcd_pkg::masks_t               masks
);
    import slcd_pkg::*;

    logic [MASK_W-1:0] enabled_reg;
    logic [MASK_W-1:0] flash_yellow_reg;
    logic [MASK_W-1:0] flash_red_reg;
    masks_t            masks_reg;
    masks_t            masks_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enabled_reg      <= ENABLED_RESET;
            flash_yellow_reg <= FLASH_YELLOW_RESET;
            flash_red_reg    <= FLASH_RED_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_CHANNEL_ENABLED: enabled_reg      <= cfg_data;
                REG_FLASH_YELLOW:    flash_yellow_reg <= cfg_data;
                REG_FLASH_RED:       flash_red_reg    <= cfg_data;
                default:             ;
            endcase
        end
    end

    always_comb
    begin
        masks_next = masks_reg;
        if (take)
        begin
            unique case (kind)
                KIND_LOAD:
                    masks_next = load_masks;
                KIND_AUTOFLASH:
                begin
                    masks_next.green  = '0;
                    masks_next.yellow = enabled_reg & flash_yellow_reg;
                    masks_next.red    = enabled_reg & flash_red_reg;
                    masks_next.flash  = enabled_reg;
                end
                KIND_ALL_RED:
                begin
                    masks_next       = '0;
                    masks_next.red   = enabled_reg;
                end
                KIND_OFF:
                    masks_next = '0;
                default:
                    masks_next = masks_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            masks_reg <= '0;
        else
            masks_reg <= masks_next;
    end

    assign masks = masks_reg;

endmodule

`default_nettype wire

/* hw/rtl/slcd_seq.sv */
`timescale 1ns / 1ps
`default_nettype none

module slcd_seq (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    input  logic [slcd_pkg::KIND_W-1:0]  kind,
    input  logic [slcd_pkg::TICK_W-1:0]  tick_count,
    output logic                         in_stall,
    output logic                         take,
    output logic [slcd_pkg::BOARD_W-1:0] board_sel,
    output logic                         late,
    input  slcd_pkg::codes_t             codes,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic [slcd_pkg::BOARD_W-1:0] board,
    output logic [slcd_pkg::LAMP_W-1:0]  lamp_first,
    output logic [slcd_pkg::LAMP_W-1:0]  lamp_second,
    output logic [slcd_pkg::LAMP_W-1:0]  lamp_third,
    output logic [slcd_pkg::LAMP_W-1:0]  lamp_fourth,
    output logic                         run_pulse,
    output logic                         last
);
    import slcd_pkg::*;

    logic                pend_reg;
    logic [BOARD_W-1:0]  board_reg;
    logic [TICK_W-1:0]   tick_reg;
    logic                out_valid_reg;
    logic [BOARD_W-1:0]  board_out_reg;
    codes_t              codes_reg;
    logic                run_reg;
    logic                last_reg;
    logic                load_en;
    logic                last_load;

    assign load_en   = pend_reg && (!out_valid_reg || !out_stall);
    assign last_load = load_en && (board_reg == LAST_BOARD);
    // a new request may enter as the final board of a tick moves out
    assign in_stall  = pend_reg && !last_load;
    assign take      = in_valid && !in_stall;
    assign board_sel = board_reg;
    assign late      = (tick_reg >= FLASH_SPLIT);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg  <= 1'b0;
            board_reg <= '0;
        end
        else if (take && (kind == KIND_TICK))
        begin
            pend_reg  <= 1'b1;
            board_reg <= '0;
        end
        else if (load_en)
        begin
            pend_reg  <= !last_load;
            board_reg <= board_reg + BOARD_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (take && (kind == KIND_TICK))
            tick_reg <= tick_count;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (load_en)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    // merge the lane codes into one board result
    always_ff @(posedge clk)
    begin
        if (load_en)
        begin
            board_out_reg <= board_reg;
            codes_reg     <= codes;
            run_reg       <= (tick_reg < RUN_TICKS);
            last_reg      <= (board_reg == LAST_BOARD);
        end
    end

    assign out_valid   = out_valid_reg;
    assign board       = board_out_reg;
    assign lamp_first  = codes_reg[0];
    assign lamp_second = codes_reg[1];
    assign lamp_third  = codes_reg[2];
    assign lamp_fourth = codes_reg[3];
    assign run_pulse   = run_reg;
    assign last        = last_reg;

endmodule

`default_nettype wire

/* hw/rtl/signal_lamp_channel_driver.sv */
`timescale 1ns / 1ps
`default_nettype none

// channel   handshake              payload
// -------   --------------------   ------------------------------------------
// in        in_valid / in_stall    kind, green/yellow/red/flash_mask, tick_count
// out       out_valid / out_stall  board, lamp_first..fourth, run_pulse, last
// cfg       cfg_write              cfg_index, cfg_data
//
// A tick request yields one board result per cycle unless out_stall holds,
// one for each of eight boards; the board counter steps the four lamp lanes.
// Mode and status requests yield no board result.
// Reset clears all lamp masks (all dark) and loads the register defaults.
// While a tick is still emitting, in_stall holds until its last board moves
// into the output register; out_stall holds the output register.

module signal_lamp_channel_driver (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_write,
    input  logic [slcd_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [slcd_pkg::MASK_W-1:0]    cfg_data,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic [slcd_pkg::KIND_W-1:0]    kind,
    input  logic [slcd_pkg::MASK_W-1:0]    green_mask,
    input  logic [slcd_pkg::MASK_W-1:0]    yellow_mask,
    input  logic [slcd_pkg::MASK_W-1:0]    red_mask,
    input  logic [slcd_pkg::MASK_W-1:0]    flash_mask,
    input  logic [slcd_pkg::TICK_W-1:0]    tick_count,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [slcd_pkg::BOARD_W-1:0]   board,
    output logic [slcd_pkg::LAMP_W-1:0]    lamp_first,
    output logic [slcd_pkg::LAMP_W-1:0]    lamp_second,
    output logic [slcd_pkg::LAMP_W-1:0]    lamp_third,
    output logic [slcd_pkg::LAMP_W-1:0]    lamp_fourth,
    output logic                           run_pulse,
    output logic                           last
);
    import slcd_pkg::*;

    masks_t             load_masks;
    masks_t             masks;
    logic               take;
    logic [BOARD_W-1:0] board_sel;
    logic               late;
    codes_t             codes;

    assign load_masks.green  = green_mask;
    assign load_masks.yellow = yellow_mask;
    assign load_masks.red    = red_mask;
    assign load_masks.flash  = flash_mask;

    slcd_state u_state (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_write  (cfg_write),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .take       (take),
        .kind       (kind),
        .load_masks (load_masks),
        .masks      (masks)
    );

    for (genvar l = 0; l < LANES; l++)
    begin : g_lane
        localparam logic [1:0] LANE_ID = 2'(l);
        logic [CH_W-1:0] ch;
        lamp_bits_t      bits;

        assign ch          = {board_sel, LANE_ID};
        assign bits.green  = masks.green[ch];
        assign bits.yellow = masks.yellow[ch];
        assign bits.red    = masks.red[ch];
        assign bits.flash  = masks.flash[ch];

        slcd_lane u_lane (
            .bits (bits),
            .late (late),
            .code (codes[l])
        );
    end

    slcd_seq u_seq (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .kind        (kind),
        .tick_count  (tick_count),
        .in_stall    (in_stall),
        .take        (take),
        .board_sel   (board_sel),
        .late        (late),
        .codes       (codes),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .board       (board),
        .lamp_first  (lamp_first),
        .lamp_second (lamp_second),
        .lamp_third  (lamp_third),
        .lamp_fourth (lamp_fourth),
        .run_pulse   (run_pulse),
        .last        (last)
    );

endmodule

`default_nettype wire
